// ===== hdl/crc64rb_pkg.sv =====
// Shared constants and types for the reflected byte-wise CRC-64 block.
package crc64rb_pkg;

  localparam int CrcWidth  = 64;
  localparam int ByteWidth = 8;

  typedef logic [CrcWidth-1:0]  crc_t;
  typedef logic [ByteWidth-1:0] byte_t;

  // Reflected ISO 3309 polynomial
  localparam crc_t CrcPoly = 64'hD800_0000_0000_0000;

  // Running value after reset and at the start of a message
  localparam crc_t CrcInit = '0;

endpackage : crc64rb_pkg

// ===== hdl/crc64rb_fold.sv =====
// Combinational fold of one data byte into the reflected CRC-64 value.
module crc64rb_fold (
  input  crc64rb_pkg::crc_t  crc_in,
  input  crc64rb_pkg::byte_t data,
  output crc64rb_pkg::crc_t  crc_out
);
  import crc64rb_pkg::*;

  // Xor the byte into the low end, then eight shift-right steps with
  // conditional polynomial xor
  always_comb begin
    crc_t v;
    v = crc_in ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int k = 0; k < ByteWidth; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CrcPoly;
      end else begin
        v = v >> 1;
      end
    end
    crc_out = v;
  end

endmodule : crc64rb_fold

// ===== hdl/crc64_reflected_bytewise.sv =====
// Top level: reflected CRC-64 over a byte stream with first/last marks.
//
// Usage:
//   Input channel (data_valid / data_stall) carries one byte per beat with
//   first_byte and last_byte marks. A beat is taken at a rising edge with
//   data_valid high and data_stall low. A first mark restarts the CRC from
//   zero; a byte without one continues from the stored running value.
//   Output channel (crc_valid / crc_stall) carries crc_value, one beat per
//   message, produced for the byte that carries the last mark.
// Timing:
//   One byte per cycle sustained while data_stall stays low. A byte waits
//   in the input register; the single combinational byte fold runs between
//   that register and the running CRC register, so crc_valid rises as the
//   last byte leaves the input register.
// Reset:
//   rst clears both valid flags and sets the running CRC to zero.
// Backpressure:
//   While a result waits under crc_stall, bytes without a last mark keep
//   flowing; a last byte holds in the input register and data_stall rises
//   until the output beat is taken.
module crc64_reflected_bytewise (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_stall,
  input  crc64rb_pkg::byte_t data_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  output logic               crc_valid,
  input  logic               crc_stall,
  output crc64rb_pkg::crc_t  crc_value
);
  import crc64rb_pkg::*;

  // Input register
  logic  in_q_valid;
  byte_t in_q_data;
  logic  in_q_first;
  logic  in_q_last;

  // Running CRC
  crc_t crc_reg;
  crc_t crc_base;
  crc_t crc_fold;

  logic in_move;
  logic in_take;
  logic out_free;

  // Output register is free when empty or drained this cycle
  assign out_free = !crc_valid || !crc_stall;

  // Advance the input register unless a last byte meets a blocked output
  assign in_move    = in_q_valid && (!in_q_last || out_free);
  assign data_stall = in_q_valid && !in_move;
  assign in_take    = data_valid && !data_stall;

  // Hold or load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (in_move) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_data  <= data_byte;
      in_q_first <= first_byte;
      in_q_last  <= last_byte;
    end
  end

  // Restart from zero on a first mark
  assign crc_base = in_q_first ? CrcInit : crc_reg;

  crc64rb_fold u_fold (
    .crc_in  (crc_base),
    .data    (in_q_data),
    .crc_out (crc_fold)
  );

  // Advance the running CRC
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= CrcInit;
    end else if (in_move) begin
      crc_reg <= crc_fold;
    end
  end

  // Load the result register on a last byte, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_valid <= 1'b0;
    end else if (in_move && in_q_last) begin
      crc_valid <= 1'b1;
    end else if (!crc_stall) begin
      crc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move && in_q_last) begin
      crc_value <= crc_fold;
    end
  end

`ifndef SYNTHESIS
  // A blocked result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    crc_valid && crc_stall |=> crc_valid && $stable(crc_value))
    else $error("result changed while stalled");

  // Stall only for a last byte facing a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> in_q_valid && in_q_last && crc_valid && crc_stall)
    else $error("input stalled without cause");

  // A result appears exactly when a last byte leaves the input register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    in_move && in_q_last |=> crc_valid && (crc_value == crc_reg))
    else $error("result not loaded from fold");

  // A held input item survives the stall
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    data_stall |=> in_q_valid && in_q_last)
    else $error("stalled input item lost");

  // Nothing valid right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !crc_valid && !in_q_valid)
    else $error("valid set after reset");
`endif

endmodule : crc64_reflected_bytewise
